>>> hdl/ecef_pkg.sv
`default_nettype none
package ecef_pkg;

	localparam int MAX_ITERATIONS   = 8;
	localparam int MATRIX_FRAC_BITS = 30;
	localparam int CORDIC_STEPS     = 32;
	localparam int LEN_FRAC         = 8;
	localparam int ITER_W           = $clog2(MAX_ITERATIONS);
	localparam int STEP_W           = $clog2(CORDIC_STEPS);
	localparam int OUT_SHIFT        = 60 - MATRIX_FRAC_BITS;
	localparam int TOL_W            = 21;

	typedef logic signed [63:0] s64_t;
	typedef logic signed [33:0] ang_t;
	typedef logic [6:0]         shamt_t;
	typedef logic [5:0]         norm_t;

	localparam s64_t KINV_Q32   = 64'sd2608131496;
	localparam s64_t KINV_START = KINV_Q32 <<< 28;
	localparam s64_t PI4_Q32    = 64'sd3373259426;
	localparam s64_t E2_Q40     = 64'sd7360548640;
	localparam s64_t A_Q8       = 64'sd1632803072000;
	localparam s64_t ONE_Q60    = 64'sd1152921504606846976;
	localparam s64_t THREE_Q60  = 3 * ONE_Q60;
	localparam s64_t INT64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam s64_t NORM_COARSE = 64'sd1 <<< 50;
	localparam s64_t NORM_FINE   = 64'sd1 <<< 58;
	localparam s64_t OUT_RND    = 64'sd1 <<< (OUT_SHIFT - 1);
	localparam ang_t QUARTER    = 34'sd1073741824;
	localparam ang_t HALF       = 34'sd2147483648;
	localparam logic [TOL_W-1:0] TOL_RESET = 21'd537;

	localparam shamt_t SH_LEN = 7'(32 - LEN_FRAC);
	localparam shamt_t SH_Q32 = 7'd32;
	localparam shamt_t SH_Q40 = 7'd40;
	localparam shamt_t SH_Q60 = 7'd60;
	localparam shamt_t SH_Q61 = 7'd61;

	typedef struct packed {
		logic   start;
		s64_t   a;
		s64_t   b;
		shamt_t sh;
	} mul_req_t;

	typedef struct packed {
		logic done;
		s64_t res;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic rotate;
		s64_t x;
		s64_t y;
		ang_t ang;
	} cor_req_t;

	typedef struct packed {
		logic  done;
		s64_t  x;
		s64_t  y;
		ang_t  ang;
		norm_t sh;
	} cor_rsp_t;

	function automatic logic [29:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h20000000;
			5'd1:  v = 30'h12E4051E;
			5'd2:  v = 30'h09FB385B;
			5'd3:  v = 30'h051111D4;
			5'd4:  v = 30'h028B0D43;
			5'd5:  v = 30'h0145D7E1;
			5'd6:  v = 30'h00A2F61E;
			5'd7:  v = 30'h00517C55;
			5'd8:  v = 30'h0028BE53;
			5'd9:  v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2FA;
			5'd15: v = 30'h0000517D;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A30;
			5'd19: v = 30'h00000518;
			5'd20: v = 30'h0000028C;
			5'd21: v = 30'h00000146;
			5'd22: v = 30'h000000A3;
			5'd23: v = 30'h00000051;
			5'd24: v = 30'h00000029;
			5'd25: v = 30'h00000014;
			5'd26: v = 30'h0000000A;
			5'd27: v = 30'h00000005;
			5'd28: v = 30'h00000003;
			5'd29: v = 30'h00000001;
			5'd30: v = 30'h00000001;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

	function automatic ang_t clamp_ang(input ang_t v, input ang_t lim);
		ang_t r;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		else
			r = v;
		return r;
	endfunction

	// clamp to +-1, round half away from zero to the matrix format, keep low 32 bits
	function automatic logic [31:0] out_q(input s64_t v);
		s64_t c;
		s64_t m;
		s64_t r;
		if (v > ONE_Q60)
			c = ONE_Q60;
		else if (v < -ONE_Q60)
			c = -ONE_Q60;
		else
			c = v;
		m = (c < 0) ? -c : c;
		r = (m + OUT_RND) >>> OUT_SHIFT;
		if (c < 0)
			r = -r;
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/ecef_mul.sv
`default_nettype none
module ecef_mul import ecef_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_PP   = 3'd1;
	localparam logic [2:0] M_RND  = 3'd2;
	localparam logic [2:0] M_SHF  = 3'd3;
	localparam logic [2:0] M_DONE = 3'd4;

	logic [2:0]   phase_q;
	logic [1:0]   cnt_q;
	logic [63:0]  ua_q;
	logic [63:0]  ub_q;
	logic         neg_q;
	shamt_t       sh_q;
	logic [127:0] acc_q;
	s64_t         res_q;

	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [63:0]  prod;
	logic [1:0]   sel;
	logic [127:0] addend;
	logic [127:0] rnd;
	logic [127:0] shifted;
	s64_t         mag;

	always_comb begin
		pa   = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb   = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		prod = pa * pb;
		sel  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		case (sel)
			2'd0:    addend = {64'd0, prod};
			2'd1:    addend = {32'd0, prod, 32'd0};
			default: addend = {prod, 64'd0};
		endcase
		rnd     = (sh_q == '0) ? 128'd0 : (128'd1 << (sh_q - 7'd1));
		shifted = acc_q >> sh_q;
		mag     = (|shifted[127:63]) ? INT64_MAX : s64_t'({1'b0, shifted[62:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				M_IDLE: begin
					if (req.start) begin
						ua_q    <= req.a[63] ? 64'(-req.a) : 64'(req.a);
						ub_q    <= req.b[63] ? 64'(-req.b) : 64'(req.b);
						neg_q   <= req.a[63] ^ req.b[63];
						sh_q    <= req.sh;
						acc_q   <= '0;
						cnt_q   <= '0;
						phase_q <= M_PP;
					end
				end
				M_PP: begin
					acc_q <= acc_q + addend;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3)
						phase_q <= M_RND;
				end
				M_RND: begin
					acc_q   <= acc_q + rnd;
					phase_q <= M_SHF;
				end
				M_SHF: begin
					res_q   <= neg_q ? -mag : mag;
					phase_q <= M_DONE;
				end
				default: phase_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = (phase_q == M_DONE);
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

>>> hdl/ecef_cordic.sv
`default_nettype none
module ecef_cordic import ecef_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  cor_req_t req,
	output cor_rsp_t rsp
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;
	localparam logic [1:0] C_DONE = 2'd3;

	logic [1:0]        phase_q;
	logic              rot_q;
	logic              neg_q;
	logic [STEP_W-1:0] i_q;
	s64_t              x_q;
	s64_t              y_q;
	ang_t              ang_q;
	norm_t             sh_q;

	s64_t dx;
	s64_t dy;
	s64_t ay;
	s64_t mx;
	ang_t atan_v;
	logic go_pos;

	always_comb begin
		dx     = y_q >>> i_q;
		dy     = x_q >>> i_q;
		ay     = (y_q < 0) ? -y_q : y_q;
		mx     = (x_q > ay) ? x_q : ay;
		atan_v = ang_t'({4'b0000, atan_tab(i_q)});
		// vectoring drives y to zero, rotation drives the angle to zero
		go_pos = rot_q ? (ang_q >= 0) : (y_q < 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= C_IDLE;
			rot_q   <= 1'b0;
			neg_q   <= 1'b0;
			i_q     <= '0;
		end else begin
			case (phase_q)
				C_IDLE: begin
					if (req.start) begin
						i_q   <= '0;
						sh_q  <= '0;
						rot_q <= req.rotate;
						if (req.rotate) begin
							x_q     <= KINV_START;
							y_q     <= '0;
							phase_q <= C_ITER;
							if (req.ang > QUARTER) begin
								ang_q <= req.ang - HALF;
								neg_q <= 1'b1;
							end else if (req.ang < -QUARTER) begin
								ang_q <= req.ang + HALF;
								neg_q <= 1'b1;
							end else begin
								ang_q <= req.ang;
								neg_q <= 1'b0;
							end
						end else begin
							neg_q <= 1'b0;
							if (req.x == 0 && req.y == 0) begin
								x_q     <= '0;
								y_q     <= '0;
								ang_q   <= '0;
								phase_q <= C_DONE;
							end else if (req.x < 0) begin
								phase_q <= C_NORM;
								if (req.y >= 0) begin
									x_q   <= req.y;
									y_q   <= -req.x;
									ang_q <= QUARTER;
								end else begin
									x_q   <= -req.y;
									y_q   <= req.x;
									ang_q <= -QUARTER;
								end
							end else begin
								x_q     <= req.x;
								y_q     <= req.y;
								ang_q   <= '0;
								phase_q <= C_NORM;
							end
						end
					end
				end
				C_NORM: begin
					if (mx < NORM_COARSE) begin
						x_q  <= x_q <<< 8;
						y_q  <= y_q <<< 8;
						sh_q <= sh_q + norm_t'(8);
					end else if (mx < NORM_FINE) begin
						x_q  <= x_q <<< 1;
						y_q  <= y_q <<< 1;
						sh_q <= sh_q + norm_t'(1);
					end else begin
						phase_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (go_pos) begin
						x_q   <= x_q - dx;
						y_q   <= y_q + dy;
					end else begin
						x_q   <= x_q + dx;
						y_q   <= y_q - dy;
					end
					if (go_pos)
						ang_q <= ang_q - atan_v;
					else
						ang_q <= ang_q + atan_v;
					i_q <= i_q + 1'b1;
					if (i_q == STEP_W'(CORDIC_STEPS - 1))
						phase_q <= C_DONE;
				end
				default: phase_q <= C_IDLE;
			endcase
		end
	end

	assign rsp.done = (phase_q == C_DONE);
	assign rsp.x    = neg_q ? -x_q : x_q;
	assign rsp.y    = neg_q ? -y_q : y_q;
	assign rsp.ang  = ang_q;
	assign rsp.sh   = sh_q;

endmodule
`default_nettype wire

>>> hdl/ecef_to_enu_rotation_unit.sv
// each item takes 1 to 8 refinement passes, ending early once the latitude change is under the tolerance
// each cordic vectoring pass first normalizes by shifts of 8 and then of 1 bit; x = y = 0 skips to the end
// each refinement pass is one rotation, fifteen multiplies and one vectoring pass
// the multiplier is one shared 64x64 unit and the cordic unit one shared 32-step unit
// a new item is taken once the last result has gone to the outputs, also while that result waits
// reset: arst_n clears the sequencer, output valid and sets the tolerance to 537
`default_nettype none
module ecef_to_enu_rotation_unit import ecef_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_wr_en,
	input  wire [TOL_W-1:0]         cfg_wr_data,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire signed [35:0]       pos_x_mm,
	input  wire signed [35:0]       pos_y_mm,
	input  wire signed [35:0]       pos_z_mm,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic signed [31:0]      r_east_x,
	output logic signed [31:0]      r_east_y,
	output logic signed [31:0]      r_east_z,
	output logic signed [31:0]      r_north_x,
	output logic signed [31:0]      r_north_y,
	output logic signed [31:0]      r_north_z,
	output logic signed [31:0]      r_up_x,
	output logic signed [31:0]      r_up_y,
	output logic signed [31:0]      r_up_z,
	output logic signed [30:0]      latitude_rad,
	output logic signed [31:0]      longitude_rad,
	output logic                    not_converged
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_VLON = 5'd1;
	localparam logic [4:0] S_P    = 5'd2;
	localparam logic [4:0] S_W0   = 5'd3;
	localparam logic [4:0] S_VLAT = 5'd4;
	localparam logic [4:0] S_Q0   = 5'd5;
	localparam logic [4:0] S_ROT  = 5'd6;
	localparam logic [4:0] S_S2   = 5'd7;
	localparam logic [4:0] S_T    = 5'd8;
	localparam logic [4:0] S_U    = 5'd9;
	localparam logic [4:0] S_V    = 5'd10;
	localparam logic [4:0] S_R    = 5'd11;
	localparam logic [4:0] S_N    = 5'd12;
	localparam logic [4:0] S_G    = 5'd13;
	localparam logic [4:0] S_H    = 5'd14;
	localparam logic [4:0] S_VL   = 5'd15;
	localparam logic [4:0] S_Q    = 5'd16;
	localparam logic [4:0] S_RL   = 5'd17;
	localparam logic [4:0] S_RP   = 5'd18;
	localparam logic [4:0] S_M0   = 5'd19;
	localparam logic [4:0] S_M1   = 5'd20;
	localparam logic [4:0] S_M2   = 5'd21;
	localparam logic [4:0] S_M3   = 5'd22;
	localparam logic [4:0] S_QLON = 5'd23;
	localparam logic [4:0] S_DONE = 5'd24;

	logic [4:0]        state_q;
	logic              busy_q;
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] k_q;
	logic [1:0]        n_q;
	logic              nc_q;

	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	s64_t  zq_q;
	s64_t  p_q;
	s64_t  tmp_q;
	s64_t  t_q;
	s64_t  r_q;
	s64_t  cp_q;
	s64_t  sp_q;
	s64_t  cl_q;
	s64_t  sl_q;
	ang_t  lon_q;
	ang_t  lat_q;
	ang_t  qprev_q;
	norm_t shv_q;

	logic [31:0] ex_q, ey_q, nx_q, ny_q, nz_q, ux_q, uy_q, uz_q, lon_out_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	cor_req_t creq;
	cor_rsp_t crsp;

	logic use_mul;
	logic use_cor;
	logic op_done;
	s64_t mres;
	s64_t wv;
	ang_t qv;
	logic signed [34:0] dv;
	logic [34:0] adv;
	logic out_free;

	ecef_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	ecef_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// operand selection for the shared units
	always_comb begin
		use_mul     = 1'b0;
		use_cor     = 1'b0;
		mreq.a      = '0;
		mreq.b      = '0;
		mreq.sh     = '0;
		creq.rotate = 1'b0;
		creq.x      = '0;
		creq.y      = '0;
		creq.ang    = '0;
		case (state_q)
			S_VLON: begin
				use_cor = 1'b1;
				creq.x  = s64_t'(x_q);
				creq.y  = s64_t'(y_q);
			end
			S_P: begin
				use_mul = 1'b1;
				mreq.a  = tmp_q;
				mreq.b  = KINV_Q32;
				mreq.sh = SH_LEN + shamt_t'(shv_q);
			end
			S_W0: begin
				use_mul = 1'b1;
				mreq.a  = p_q;
				mreq.b  = E2_Q40;
				mreq.sh = SH_Q40;
			end
			S_VLAT, S_VL: begin
				use_cor = 1'b1;
				creq.x  = tmp_q;
				creq.y  = zq_q;
			end
			S_Q0, S_Q: begin
				use_mul = 1'b1;
				mreq.a  = s64_t'(lat_q);
				mreq.b  = PI4_Q32;
				mreq.sh = SH_Q32;
			end
			S_ROT, S_RP: begin
				use_cor     = 1'b1;
				creq.rotate = 1'b1;
				creq.ang    = lat_q;
			end
			S_S2: begin
				use_mul = 1'b1;
				mreq.a  = sp_q;
				mreq.b  = sp_q;
				mreq.sh = SH_Q60;
			end
			S_T: begin
				use_mul = 1'b1;
				mreq.a  = E2_Q40;
				mreq.b  = t_q;
				mreq.sh = SH_Q40;
			end
			S_U: begin
				use_mul = 1'b1;
				mreq.a  = r_q;
				mreq.b  = r_q;
				mreq.sh = SH_Q60;
			end
			S_V: begin
				use_mul = 1'b1;
				mreq.a  = t_q;
				mreq.b  = tmp_q;
				mreq.sh = SH_Q60;
			end
			S_R: begin
				use_mul = 1'b1;
				mreq.a  = r_q;
				mreq.b  = tmp_q;
				mreq.sh = SH_Q61;
			end
			S_N: begin
				use_mul = 1'b1;
				mreq.a  = A_Q8;
				mreq.b  = r_q;
				mreq.sh = SH_Q60;
			end
			S_G: begin
				use_mul = 1'b1;
				mreq.a  = tmp_q;
				mreq.b  = cp_q;
				mreq.sh = SH_Q60;
			end
			S_H: begin
				use_mul = 1'b1;
				mreq.a  = tmp_q;
				mreq.b  = E2_Q40;
				mreq.sh = SH_Q40;
			end
			S_RL: begin
				use_cor     = 1'b1;
				creq.rotate = 1'b1;
				creq.ang    = lon_q;
			end
			S_M0: begin
				use_mul = 1'b1;
				mreq.a  = sp_q;
				mreq.b  = cl_q;
				mreq.sh = SH_Q60;
			end
			S_M1: begin
				use_mul = 1'b1;
				mreq.a  = sp_q;
				mreq.b  = sl_q;
				mreq.sh = SH_Q60;
			end
			S_M2: begin
				use_mul = 1'b1;
				mreq.a  = cp_q;
				mreq.b  = cl_q;
				mreq.sh = SH_Q60;
			end
			S_M3: begin
				use_mul = 1'b1;
				mreq.a  = cp_q;
				mreq.b  = sl_q;
				mreq.sh = SH_Q60;
			end
			S_QLON: begin
				use_mul = 1'b1;
				mreq.a  = s64_t'(lon_q);
				mreq.b  = PI4_Q32;
				mreq.sh = SH_Q32;
			end
			default: begin
				use_mul = 1'b0;
			end
		endcase
		mreq.start = use_mul && !busy_q;
		creq.start = use_cor && !busy_q;
		op_done    = busy_q && (use_mul ? mrsp.done : (use_cor && crsp.done));
		mres       = mrsp.res;
		wv         = p_q - mres;
		qv         = ang_t'(mres);
		dv         = 35'(qv) - 35'(qprev_q);
		adv        = (dv < 0) ? 35'(-dv) : 35'(dv);
		out_free   = !out_valid || !out_stall;
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			k_q       <= '0;
			n_q       <= '0;
			nc_q      <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			// in S_DONE the result register is reloaded below instead
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			if (mreq.start || creq.start)
				busy_q <= 1'b1;
			else if (op_done)
				busy_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q     <= pos_x_mm;
						y_q     <= pos_y_mm;
						zq_q    <= s64_t'(pos_z_mm) <<< LEN_FRAC;
						k_q     <= '0;
						nc_q    <= 1'b1;
						state_q <= S_VLON;
					end
				end
				S_VLON: if (op_done) begin
					lon_q   <= clamp_ang(crsp.ang, HALF);
					tmp_q   <= crsp.x;
					shv_q   <= crsp.sh;
					state_q <= S_P;
				end
				S_P: if (op_done) begin
					p_q     <= mres;
					state_q <= S_W0;
				end
				S_W0: if (op_done) begin
					tmp_q   <= wv;
					state_q <= S_VLAT;
				end
				S_VLAT: if (op_done) begin
					lat_q   <= clamp_ang(crsp.ang, QUARTER);
					state_q <= S_Q0;
				end
				S_Q0: if (op_done) begin
					qprev_q <= qv;
					state_q <= S_ROT;
				end
				S_ROT: if (op_done) begin
					cp_q    <= crsp.x;
					sp_q    <= crsp.y;
					state_q <= S_S2;
				end
				S_S2: if (op_done) begin
					if (mres < 0)
						t_q <= '0;
					else if (mres > ONE_Q60)
						t_q <= ONE_Q60;
					else
						t_q <= mres;
					state_q <= S_T;
				end
				S_T: if (op_done) begin
					t_q     <= ONE_Q60 - mres;
					r_q     <= ONE_Q60;
					n_q     <= '0;
					state_q <= S_U;
				end
				S_U: if (op_done) begin
					tmp_q   <= mres;
					state_q <= S_V;
				end
				S_V: if (op_done) begin
					tmp_q   <= THREE_Q60 - mres;
					state_q <= S_R;
				end
				// three newton steps toward 1/sqrt(1 - e2 sin^2 lat)
				S_R: if (op_done) begin
					r_q     <= mres;
					n_q     <= n_q + 2'd1;
					state_q <= (n_q == 2'd2) ? S_N : S_U;
				end
				S_N: if (op_done) begin
					tmp_q   <= mres;
					state_q <= S_G;
				end
				S_G: if (op_done) begin
					tmp_q   <= mres;
					state_q <= S_H;
				end
				S_H: if (op_done) begin
					tmp_q   <= (wv < 0) ? s64_t'(0) : wv;
					state_q <= S_VL;
				end
				S_VL: if (op_done) begin
					lat_q   <= clamp_ang(crsp.ang, QUARTER);
					state_q <= S_Q;
				end
				S_Q: if (op_done) begin
					qprev_q <= qv;
					if (adv < 35'(tol_q)) begin
						nc_q    <= 1'b0;
						state_q <= S_RL;
					end else if (k_q == ITER_W'(MAX_ITERATIONS - 1)) begin
						state_q <= S_RL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ROT;
					end
				end
				S_RL: if (op_done) begin
					cl_q    <= crsp.x;
					sl_q    <= crsp.y;
					ex_q    <= out_q(-crsp.y);
					ey_q    <= out_q(crsp.x);
					state_q <= S_RP;
				end
				S_RP: if (op_done) begin
					cp_q    <= crsp.x;
					sp_q    <= crsp.y;
					nz_q    <= out_q(crsp.x);
					uz_q    <= out_q(crsp.y);
					state_q <= S_M0;
				end
				S_M0: if (op_done) begin
					nx_q    <= out_q(-mres);
					state_q <= S_M1;
				end
				S_M1: if (op_done) begin
					ny_q    <= out_q(-mres);
					state_q <= S_M2;
				end
				S_M2: if (op_done) begin
					ux_q    <= out_q(mres);
					state_q <= S_M3;
				end
				S_M3: if (op_done) begin
					uy_q    <= out_q(mres);
					state_q <= S_QLON;
				end
				S_QLON: if (op_done) begin
					lon_out_q <= mres[31:0];
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						r_east_x      <= ex_q;
						r_east_y      <= ey_q;
						r_east_z      <= '0;
						r_north_x     <= nx_q;
						r_north_y     <= ny_q;
						r_north_z     <= nz_q;
						r_up_x        <= ux_q;
						r_up_y        <= uy_q;
						r_up_z        <= uz_q;
						latitude_rad  <= qprev_q[30:0];
						longitude_rad <= lon_out_q;
						not_converged <= nc_q;
						out_valid     <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/ecef_chk.sv
`default_nettype none
module ecef_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] r_east_z,
	input wire signed [30:0] latitude_rad
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// an accepted item keeps the input side busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not held off after accept");

	// a result cannot appear in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> r_east_z == 32'sd0 &&
			latitude_rad <= 31'sd843314857 && latitude_rad >= -31'sd843314857)
		else $error("result out of range");

endmodule

bind ecef_to_enu_rotation_unit ecef_chk u_ecef_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.r_east_z     (r_east_z),
	.latitude_rad (latitude_rad)
);
`default_nettype wire
